// ===== sv/rpsq_pkg.sv =====
// ----------------------------------------------------------------------------
// rpsq_pkg
// Shared types and constants of the range product sign query block.
// ----------------------------------------------------------------------------
package rpsq_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned POS_W  = 11;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SIGN_W = 2;

  // Operation carried by an input item.
  typedef enum logic {
    CMD_CHANGE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  // Sign class of an element, also the code of a query result.
  typedef enum logic [SIGN_W-1:0] {
    SIGN_ZERO = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_e;

  // Finished query result handed from the sequencer to the output stage.
  typedef struct packed {
    logic  valid;
    sign_e sign;
  } res_t;

endpackage

// ===== sv/rpsq_node_ram.sv =====
// ----------------------------------------------------------------------------
// rpsq_node_ram
// Single memory of tree nodes: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module rpsq_node_ram #(
  parameter int unsigned WORD_W = 14,
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DEPTH  = 1024
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WORD_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data shows in the cycle after the address is given.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/rpsq_seq.sv =====
// ----------------------------------------------------------------------------
// rpsq_seq
// Sequencer: clears the node memory after reset, then walks the Fenwick
// tree one node per cycle for each valid change or non-empty query item.
// ----------------------------------------------------------------------------
module rpsq_seq #(
  parameter int unsigned NUM_ELEMENTS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic        [rpsq_pkg::POS_W-1:0] position_i,
  input  logic signed [rpsq_pkg::VAL_W-1:0] new_value_i,
  input  logic        [rpsq_pkg::POS_W-1:0] range_left_i,
  input  logic        [rpsq_pkg::POS_W-1:0] range_right_i,
  output rpsq_pkg::res_t                    res_o,
  input  logic                              res_ready_i,
  output logic                              rd_en_o,
  output logic [$clog2(NUM_ELEMENTS)-1:0]   rd_addr_o,
  input  logic [$clog2(NUM_ELEMENTS+1)+2:0] rd_data_i,
  output logic                              wr_en_o,
  output logic [$clog2(NUM_ELEMENTS)-1:0]   wr_addr_o,
  output logic [$clog2(NUM_ELEMENTS+1)+2:0] wr_data_o
);

  import rpsq_pkg::*;

  // Node index 1..NUM_ELEMENTS, memory address is index minus one.
  localparam int unsigned IDX_W  = $clog2(NUM_ELEMENTS + 1);
  localparam int unsigned ADDR_W = $clog2(NUM_ELEMENTS);
  localparam int unsigned CNT_W  = IDX_W;
  localparam int unsigned WORD_W = CNT_W + 3;
  localparam logic [31:0] NUM_32 = 32'(NUM_ELEMENTS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_ELEMENTS - 1);
  localparam logic [IDX_W:0] NUM_EXT = (IDX_W + 1)'(NUM_ELEMENTS);

  // Node word: element class, zero count and negative parity.
  localparam int unsigned CLS_HI = WORD_W - 1;
  localparam int unsigned CLS_LO = WORD_W - 2;
  localparam int unsigned CNT_HI = CNT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD,
    S_QRY,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  lom1_q, lom1_d;
  logic              first_q, first_d;
  logic              phase_q, phase_d;
  logic [1:0]        cls_q, cls_d;
  logic              zinc_q, zinc_d;
  logic              zdec_q, zdec_d;
  logic              flip_q, flip_d;
  logic [CNT_W-1:0]  zacc_q, zacc_d;
  logic              par_q, par_d;
  sign_e             sign_q, sign_d;

  // Decoded item fields.
  logic [31:0]      pos_32, lo_32, hi_raw_32, hi_32, lom1_32;
  logic             pos_ok, range_empty;
  logic [1:0]       new_cls;

  // Node walk arithmetic.
  logic [IDX_W-1:0] low_bit, dn_nxt, cur_m1, rd_m1, rd_idx;
  logic [IDX_W:0]   up_nxt;
  logic [1:0]       rd_cls;
  logic [CNT_W-1:0] rd_cnt, z_delta, z_new;
  logic             rd_par, par_new;
  logic             zinc, zdec, flip;
  logic             old_zero, old_neg, new_zero, new_neg;

  // Item decode and range clamping.
  always_comb begin
    pos_32      = 32'(position_i);
    pos_ok      = (pos_32 != 32'd0) && (pos_32 <= NUM_32);
    lo_32       = (range_left_i == '0) ? 32'd1 : 32'(range_left_i);
    hi_raw_32   = 32'(range_right_i);
    hi_32       = (hi_raw_32 > NUM_32) ? NUM_32 : hi_raw_32;
    lom1_32     = lo_32 - 32'd1;
    range_empty = lo_32 > hi_32;
    if (new_value_i == '0) begin
      new_cls = SIGN_ZERO;
    end else if (new_value_i[VAL_W-1]) begin
      new_cls = SIGN_NEG;
    end else begin
      new_cls = SIGN_POS;
    end
  end

  // Fields of the node that the memory returns this cycle.
  assign rd_cls = rd_data_i[CLS_HI:CLS_LO];
  assign rd_cnt = rd_data_i[CNT_HI:1];
  assign rd_par = rd_data_i[0];

  // Lowest set bit of the current index gives the next node.
  assign low_bit = idx_q & (~idx_q + IDX_W'(1));
  assign up_nxt  = {1'b0, idx_q} + {1'b0, low_bit};
  assign dn_nxt  = idx_q - low_bit;
  assign cur_m1  = idx_q - IDX_W'(1);
  assign rd_m1   = rd_idx - IDX_W'(1);

  // Class change seen at the first node of an update walk.
  assign old_zero = rd_cls == SIGN_ZERO;
  assign old_neg  = rd_cls == SIGN_NEG;
  assign new_zero = cls_q == SIGN_ZERO;
  assign new_neg  = cls_q == SIGN_NEG;
  assign zinc     = first_q ? (new_zero && !old_zero) : zinc_q;
  assign zdec     = first_q ? (old_zero && !new_zero) : zdec_q;
  assign flip     = first_q ? (old_neg ^ new_neg) : flip_q;
  assign z_delta  = zinc ? CNT_W'(1) : (zdec ? '1 : '0);

  // Query accumulation for the node read this cycle.
  assign z_new   = phase_q ? (zacc_q - rd_cnt) : (zacc_q + rd_cnt);
  assign par_new = par_q ^ rd_par;

  // Next-state logic and memory control.
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    idx_d     = idx_q;
    lom1_d    = lom1_q;
    first_d   = first_q;
    phase_d   = phase_q;
    cls_d     = cls_q;
    zinc_d    = zinc_q;
    zdec_d    = zdec_q;
    flip_d    = flip_q;
    zacc_d    = zacc_q;
    par_d     = par_q;
    sign_d    = sign_q;
    rd_en_o   = 1'b0;
    rd_idx    = idx_q;
    wr_en_o   = 1'b0;
    wr_addr_o = cur_m1[ADDR_W-1:0];
    wr_data_o = '0;

    case (state_q)
      // Sweep the memory once: every element positive, all counts zero.
      S_CLEAR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = clr_q;
        wr_data_o = {SIGN_POS, {CNT_W{1'b0}}, 1'b0};
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end

      // Take an item, read its first node; none for a bad position or empty range.
      S_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == CMD_CHANGE) begin
            if (pos_ok) begin
              idx_d   = pos_32[IDX_W-1:0];
              rd_idx  = pos_32[IDX_W-1:0];
              rd_en_o = 1'b1;
              first_d = 1'b1;
              cls_d   = new_cls;
              state_d = S_UPD;
            end
          end else if (range_empty) begin
            sign_d  = SIGN_POS;
            state_d = S_DONE;
          end else begin
            idx_d   = hi_32[IDX_W-1:0];
            rd_idx  = hi_32[IDX_W-1:0];
            rd_en_o = 1'b1;
            lom1_d  = lom1_32[IDX_W-1:0];
            phase_d = 1'b0;
            zacc_d  = '0;
            par_d   = 1'b0;
            state_d = S_QRY;
          end
        end
      end

      // Update walk: write back the node, read the next one upward.
      S_UPD: begin
        wr_en_o   = 1'b1;
        wr_data_o = {(first_q ? cls_q : rd_cls), rd_cnt + z_delta, rd_par ^ flip};
        first_d   = 1'b0;
        zinc_d    = zinc;
        zdec_d    = zdec;
        flip_d    = flip;
        if (up_nxt > NUM_EXT) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = up_nxt[IDX_W-1:0];
          rd_idx  = up_nxt[IDX_W-1:0];
          rd_en_o = 1'b1;
        end
      end

      // Query walk: prefix of the right end, then minus the prefix before the left end.
      S_QRY: begin
        zacc_d = z_new;
        par_d  = par_new;
        if (dn_nxt != '0) begin
          idx_d   = dn_nxt;
          rd_idx  = dn_nxt;
          rd_en_o = 1'b1;
        end else if (!phase_q && (lom1_q != '0)) begin
          phase_d = 1'b1;
          idx_d   = lom1_q;
          rd_idx  = lom1_q;
          rd_en_o = 1'b1;
        end else begin
          if (z_new != '0) begin
            sign_d = SIGN_ZERO;
          end else if (par_new) begin
            sign_d = SIGN_NEG;
          end else begin
            sign_d = SIGN_POS;
          end
          state_d = S_DONE;
        end
      end

      // Hand the result over once the output stage has room.
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rd_addr_o  = rd_m1[ADDR_W-1:0];
  assign in_stall_o = state_q != S_IDLE;
  assign res_o      = '{valid: state_q == S_DONE, sign: sign_q};

  // State and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      idx_q   <= '0;
      lom1_q  <= '0;
      first_q <= 1'b0;
      phase_q <= 1'b0;
      cls_q   <= SIGN_POS;
      zinc_q  <= 1'b0;
      zdec_q  <= 1'b0;
      flip_q  <= 1'b0;
      zacc_q  <= '0;
      par_q   <= 1'b0;
      sign_q  <= SIGN_POS;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      idx_q   <= idx_d;
      lom1_q  <= lom1_d;
      first_q <= first_d;
      phase_q <= phase_d;
      cls_q   <= cls_d;
      zinc_q  <= zinc_d;
      zdec_q  <= zdec_d;
      flip_q  <= flip_d;
      zacc_q  <= zacc_d;
      par_q   <= par_d;
      sign_q  <= sign_d;
    end
  end

endmodule

// ===== sv/rpsq_out_stage.sv =====
// ----------------------------------------------------------------------------
// rpsq_out_stage
// Output register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module rpsq_out_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rpsq_pkg::res_t                res_i,
  output logic                          res_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rpsq_pkg::SIGN_W-1:0]   product_sign_o
);

  import rpsq_pkg::*;

  logic              valid_q, valid_d;
  logic [SIGN_W-1:0] sign_q;
  logic              load;

  // The slot is free when empty or when its item leaves this cycle.
  assign res_ready_o = !valid_q || !out_stall_i;
  assign load        = res_i.valid && res_ready_o;
  assign valid_d     = load || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload, loaded only with a new item.
  always_ff @(posedge clk_i) begin
    if (load) begin
      sign_q <= res_i.sign;
    end
  end

  assign out_valid_o    = valid_q;
  assign product_sign_o = sign_q;

endmodule

// ===== sv/range_product_sign_query_core.sv =====
// ----------------------------------------------------------------------------
// range_product_sign_query_core
// Sign of the product over a range of elements, kept as Fenwick trees of
// zero counts and negative parities in one node memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries change and query items.
//   A change item sets one element's sign class and gives no result. A
//   query item gives one result item on the output channel
//   (out_valid_o / out_stall_i): 0 zero, 1 positive, 2 negative.
//   After reset the block sweeps the whole node memory (every element
//   positive) with in_stall_o high, then takes items.
//   A change is accepted with the read of its first node, then one node
//   memory read-modify-write is done per cycle along the update path.
//   A query reads one node per cycle along up to two prefix paths, then
//   hands over the result once the output register has room. Items are
//   worked one at a time; the single node memory port pair sets the rate.
//   A finished result waits in the output register while the receiver
//   stalls; the next item is accepted meanwhile, and a second result waits
//   in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module range_product_sign_query_core #(
  parameter int unsigned NUM_ELEMENTS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic        [rpsq_pkg::POS_W-1:0] position_i,
  input  logic signed [rpsq_pkg::VAL_W-1:0] new_value_i,
  input  logic        [rpsq_pkg::POS_W-1:0] range_left_i,
  input  logic        [rpsq_pkg::POS_W-1:0] range_right_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic       [rpsq_pkg::SIGN_W-1:0] product_sign_o
);

  import rpsq_pkg::*;

  localparam int unsigned IDX_W  = $clog2(NUM_ELEMENTS + 1);
  localparam int unsigned ADDR_W = $clog2(NUM_ELEMENTS);
  localparam int unsigned WORD_W = IDX_W + 3;

  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [WORD_W-1:0] rd_data, wr_data;
  res_t              res;
  logic              res_ready;

  // Tree walk sequencer.
  rpsq_seq #(
    .NUM_ELEMENTS(NUM_ELEMENTS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .position_i   (position_i),
    .new_value_i  (new_value_i),
    .range_left_i (range_left_i),
    .range_right_i(range_right_i),
    .res_o        (res),
    .res_ready_i  (res_ready),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  // Node memory.
  rpsq_node_ram #(
    .WORD_W(WORD_W),
    .ADDR_W(ADDR_W),
    .DEPTH (NUM_ELEMENTS)
  ) u_ram (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  // Result register.
  rpsq_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res),
    .res_ready_o   (res_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .product_sign_o(product_sign_o)
  );

endmodule

// ===== sv/rpsq_checker.sv =====
// ----------------------------------------------------------------------------
// rpsq_checker
// Port-level checks of the range product sign query block, bound to the
// top level.
// ----------------------------------------------------------------------------
module rpsq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_i,
  input logic                        cmd_i,
  input logic                        out_valid_i,
  input logic                        out_stall_i,
  input logic [rpsq_pkg::SIGN_W-1:0] product_sign_i
);

  import rpsq_pkg::*;

  // A stalled result item stays and does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(product_sign_i))
    else $error("result item dropped or changed under stall");

  // The input is stalled right after reset, when the memory sweep starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_i)
    else $error("input taken during memory clear");

  // An accepted query makes the block go busy; it stays busy until its result is handed over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i && (cmd_i == CMD_QUERY) |=> in_stall_i)
    else $error("query accepted without going busy");

  // A new result appears only as the block finishes its query and frees its input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $fell(in_stall_i))
    else $error("result item without a finished query");

endmodule

bind range_product_sign_query_core rpsq_checker u_rpsq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_i    (in_stall_o),
  .cmd_i         (cmd_i),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .product_sign_i(product_sign_o)
);
